// ===== rtl/dagm_pkg.sv =====
// Shared types, widths and helpers for the dense AdaGrad momentum update block.
// Used by every module of the block; depends on nothing else.
package dagm_pkg;

    localparam int VECTOR_LENGTH = 1024;
    localparam int ADDR_W        = $clog2(VECTOR_LENGTH);

    localparam int IDX_W      = 10;
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 48;
    localparam int MAG_W      = 49;
    localparam int DIV_W      = 64;
    localparam int DEN_W      = 33;
    localparam int ROOT_W     = 32;
    localparam int WIDE_W     = 52;

    localparam logic [CFG_W-1:0] Q_ONE = 17'd65536;

    localparam logic [CFG_W-1:0]      LR_RESET  = 17'd655;
    localparam logic [CFG_W-1:0]      EPS_RESET = 17'd7;
    localparam logic [CFG_W-1:0]      GD_RESET  = 17'd65536;
    localparam logic [CFG_W-1:0]      MD_RESET  = 17'd58982;
    localparam logic [CFG_DATA_W-1:0] ISS_RESET = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE,
        CFG_EPSILON,
        CFG_GRAD_DECAY,
        CFG_MOMENTUM_DECAY,
        CFG_INITIAL_SQUARE_SUM
    } cfg_idx_t;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef struct packed {
        logic                    valid;
        op_t                     op;
        logic                    in_range;
        logic [IDX_W-1:0]        idx;
        logic                    neg;
        logic                    zero_den;
        logic signed [VAL_W-1:0] val;
        logic [MAG_W-1:0]        mag;
    } side_t;

    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic [SUM_W-1:0]        sum;
        logic signed [VAL_W-1:0] mom;
    } opt_state_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = 52'sd2147483647;
        lo = -52'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return signed'(v[VAL_W-1:0]);
    endfunction

endpackage

// ===== rtl/dagm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Depends on dagm_pkg for widths and the side payload type.
module dagm_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  dagm_pkg::side_t               side_in,
    input  logic [dagm_pkg::DEN_W-1:0]    rem_in,
    input  logic [dagm_pkg::DIV_W-1:0]    bits_in,
    input  logic [dagm_pkg::DEN_W-1:0]    divisor_in,
    output dagm_pkg::side_t               side_out,
    output logic [dagm_pkg::DIV_W-1:0]    quot_out
);

    dagm_pkg::side_t                side_reg [dagm_pkg::DIV_W];
    logic [dagm_pkg::DEN_W-1:0]     rem_reg  [dagm_pkg::DIV_W];
    logic [dagm_pkg::DIV_W-1:0]     qb_reg   [dagm_pkg::DIV_W];
    logic [dagm_pkg::DEN_W-1:0]     dsr_reg  [dagm_pkg::DIV_W];

    logic [dagm_pkg::DEN_W-1:0]     src_rem  [dagm_pkg::DIV_W];
    logic [dagm_pkg::DIV_W-1:0]     src_qb   [dagm_pkg::DIV_W];
    logic [dagm_pkg::DEN_W-1:0]     src_dsr  [dagm_pkg::DIV_W];
    logic [dagm_pkg::DEN_W:0]       shifted  [dagm_pkg::DIV_W];
    logic [dagm_pkg::DEN_W:0]       diff     [dagm_pkg::DIV_W];
    logic [dagm_pkg::DEN_W-1:0]     rem_next [dagm_pkg::DIV_W];
    logic [dagm_pkg::DIV_W-1:0]     qb_next  [dagm_pkg::DIV_W];

    always_comb begin
        src_rem[0] = rem_in;
        src_qb[0]  = bits_in;
        src_dsr[0] = divisor_in;
        for (int i = 1; i < dagm_pkg::DIV_W; i++) begin
            src_rem[i] = rem_reg[i-1];
            src_qb[i]  = qb_reg[i-1];
            src_dsr[i] = dsr_reg[i-1];
        end
        for (int i = 0; i < dagm_pkg::DIV_W; i++) begin
            shifted[i]  = {src_rem[i], src_qb[i][dagm_pkg::DIV_W-1]};
            diff[i]     = shifted[i] - {1'b0, src_dsr[i]};
            rem_next[i] = diff[i][dagm_pkg::DEN_W] ? shifted[i][dagm_pkg::DEN_W-1:0]
                                                   : diff[i][dagm_pkg::DEN_W-1:0];
            qb_next[i]  = {src_qb[i][dagm_pkg::DIV_W-2:0], ~diff[i][dagm_pkg::DEN_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dagm_pkg::DIV_W; i++) begin
                side_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < dagm_pkg::DIV_W; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < dagm_pkg::DIV_W; i++) begin
                rem_reg[i] <= rem_next[i];
                qb_reg[i]  <= qb_next[i];
                dsr_reg[i] <= src_dsr[i];
            end
        end
    end

    assign side_out = side_reg[dagm_pkg::DIV_W-1];
    assign quot_out = qb_reg[dagm_pkg::DIV_W-1];

endmodule

// ===== rtl/dagm_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side payload.
// Depends on dagm_pkg for widths and the side payload type.
module dagm_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  dagm_pkg::side_t               side_in,
    input  logic [dagm_pkg::DIV_W-1:0]    x_in,
    output dagm_pkg::side_t               side_out,
    output logic [dagm_pkg::ROOT_W-1:0]   root_out
);

    localparam int REM_W = dagm_pkg::ROOT_W + 2;

    dagm_pkg::side_t               side_reg [dagm_pkg::ROOT_W];
    logic [REM_W-1:0]              rem_reg  [dagm_pkg::ROOT_W];
    logic [dagm_pkg::ROOT_W-1:0]   root_reg [dagm_pkg::ROOT_W];
    logic [dagm_pkg::DIV_W-1:0]    x_reg    [dagm_pkg::ROOT_W];

    logic [REM_W-1:0]              src_rem   [dagm_pkg::ROOT_W];
    logic [dagm_pkg::ROOT_W-1:0]   src_root  [dagm_pkg::ROOT_W];
    logic [dagm_pkg::DIV_W-1:0]    src_x     [dagm_pkg::ROOT_W];
    logic [REM_W+1:0]              cur       [dagm_pkg::ROOT_W];
    logic [REM_W+1:0]              trial     [dagm_pkg::ROOT_W];
    logic                          ge        [dagm_pkg::ROOT_W];
    logic [REM_W-1:0]              rem_next  [dagm_pkg::ROOT_W];
    logic [dagm_pkg::ROOT_W-1:0]   root_next [dagm_pkg::ROOT_W];

    always_comb begin
        src_rem[0]  = '0;
        src_root[0] = '0;
        src_x[0]    = x_in;
        for (int i = 1; i < dagm_pkg::ROOT_W; i++) begin
            src_rem[i]  = rem_reg[i-1];
            src_root[i] = root_reg[i-1];
            src_x[i]    = x_reg[i-1];
        end
        for (int i = 0; i < dagm_pkg::ROOT_W; i++) begin
            cur[i]       = {src_rem[i], src_x[i][dagm_pkg::DIV_W-1 -: 2]};
            trial[i]     = {2'b00, src_root[i], 2'b01};
            ge[i]        = (cur[i] >= trial[i]);
            rem_next[i]  = ge[i] ? REM_W'(cur[i] - trial[i]) : REM_W'(cur[i]);
            root_next[i] = {src_root[i][dagm_pkg::ROOT_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dagm_pkg::ROOT_W; i++) begin
                side_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < dagm_pkg::ROOT_W; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < dagm_pkg::ROOT_W; i++) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                x_reg[i]    <= {src_x[i][dagm_pkg::DIV_W-3:0], 2'b00};
            end
        end
    end

    assign side_out = side_reg[dagm_pkg::ROOT_W-1];
    assign root_out = root_reg[dagm_pkg::ROOT_W-1];

endmodule

// ===== rtl/dense_adagrad_momentum_update.sv =====
// Dense AdaGrad update with decayed sums and momentum over a 1024-element vector.
// Datapath: stages 1 to 3, the two 64-stage dividers, the 32-stage square root,
// a final stage and the output register. Throughput: one item per cycle while the
// output is not stalled; an item whose index matches an item in stage 1 or 2 waits
// until it has written back its optimizer state. Synchronous active-low reset clears
// the pipeline and restores register defaults; the element stores are not cleared.
module dense_adagrad_momentum_update (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [dagm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dagm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic [dagm_pkg::IDX_W-1:0]           s_element_index,
    input  logic signed [dagm_pkg::VAL_W-1:0]    s_operand_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [dagm_pkg::IDX_W-1:0]           m_result_index,
    output logic signed [dagm_pkg::VAL_W-1:0]    m_new_weight
);

    logic [dagm_pkg::CFG_W-1:0]      lr_reg;
    logic [dagm_pkg::CFG_W-1:0]      eps_reg;
    logic [dagm_pkg::CFG_W-1:0]      gd_reg;
    logic [dagm_pkg::CFG_W-1:0]      md_reg;
    logic [dagm_pkg::CFG_DATA_W-1:0] iss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg  <= dagm_pkg::LR_RESET;
            eps_reg <= dagm_pkg::EPS_RESET;
            gd_reg  <= dagm_pkg::GD_RESET;
            md_reg  <= dagm_pkg::MD_RESET;
            iss_reg <= dagm_pkg::ISS_RESET;
        end else if (cfg_wr_en) begin
            unique case (dagm_pkg::cfg_idx_t'(cfg_index))
                dagm_pkg::CFG_LEARNING_RATE:      lr_reg  <= cfg_data[dagm_pkg::CFG_W-1:0];
                dagm_pkg::CFG_EPSILON:            eps_reg <= cfg_data[dagm_pkg::CFG_W-1:0];
                dagm_pkg::CFG_GRAD_DECAY:         gd_reg  <= cfg_data[dagm_pkg::CFG_W-1:0];
                dagm_pkg::CFG_MOMENTUM_DECAY:     md_reg  <= cfg_data[dagm_pkg::CFG_W-1:0];
                dagm_pkg::CFG_INITIAL_SQUARE_SUM: iss_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    dagm_pkg::side_t s1_reg, s2_reg, s3_reg, f_reg;
    dagm_pkg::side_t div1_side_in, div1_side_out, sq_side_out, div2_side_in, div2_side_out;
    logic [dagm_pkg::DIV_W-1:0]  div1_quot, div2_quot;
    logic [dagm_pkg::ROOT_W-1:0] sq_root;

    logic m_valid_reg;
    logic [dagm_pkg::IDX_W-1:0]        m_idx_reg;
    logic signed [dagm_pkg::VAL_W-1:0] m_w_reg;

    logic out_free, adv, hazard, accept, s_in_range;

    assign out_free   = !m_valid_reg || m_ready;
    assign adv        = out_free || !f_reg.valid;
    assign hazard     = (s1_reg.valid && (s1_reg.idx == s_element_index)) ||
                        (s2_reg.valid && (s2_reg.idx == s_element_index));
    assign s_ready    = adv && !hazard;
    assign accept     = s_valid && s_ready;
    assign s_in_range = (32'(s_element_index) < dagm_pkg::VECTOR_LENGTH);

    // Optimizer state memory: read on acceptance, written back from stage 2.
    dagm_pkg::opt_state_t st_mem [dagm_pkg::VECTOR_LENGTH];
    dagm_pkg::opt_state_t st_rd_reg;
    dagm_pkg::opt_state_t st_wr;

    // Stage 1: products.
    logic [dagm_pkg::MAG_W-1:0]          p_cnt, p_hi;
    logic [dagm_pkg::DEN_W-1:0]          p_lo;
    logic [dagm_pkg::VAL_W-1:0]          g_abs;
    logic [dagm_pkg::DIV_W-1:0]          g_sq;
    logic signed [dagm_pkg::VAL_W:0]     m_diff;
    logic signed [dagm_pkg::CFG_W:0]     k_fac;
    logic signed [50:0]                  m_prod;

    always_comb begin
        p_cnt  = dagm_pkg::MAG_W'(gd_reg) * dagm_pkg::MAG_W'(st_rd_reg.cnt);
        p_hi   = dagm_pkg::MAG_W'(gd_reg) * dagm_pkg::MAG_W'(st_rd_reg.sum[47:16]);
        p_lo   = dagm_pkg::DEN_W'(gd_reg) * dagm_pkg::DEN_W'(st_rd_reg.sum[15:0]);
        g_abs  = s1_reg.val[dagm_pkg::VAL_W-1] ? 32'(-s1_reg.val) : 32'(s1_reg.val);
        g_sq   = dagm_pkg::DIV_W'(g_abs) * dagm_pkg::DIV_W'(g_abs);
        m_diff = 33'(s1_reg.val) - 33'(st_rd_reg.mom);
        k_fac  = signed'({1'b0, dagm_pkg::Q_ONE}) - signed'({1'b0, md_reg});
        m_prod = 51'(m_diff) * 51'(k_fac);
    end

    logic [dagm_pkg::MAG_W-1:0]          p_cnt_reg, p_hi_reg;
    logic [16:0]                         p_lo_reg;
    logic [dagm_pkg::SUM_W-1:0]          g_sq_reg;
    logic signed [50:0]                  m_prod_reg;
    logic signed [dagm_pkg::VAL_W-1:0]   mom_reg;

    // Stage 2: sums and saturation, write-back.
    logic [33:0]                         cnt_sum;
    logic [dagm_pkg::CNT_W-1:0]          cnt_new;
    logic [49:0]                         sum_a;
    logic [dagm_pkg::SUM_W-1:0]          sum_b, sum_new;
    logic [dagm_pkg::SUM_W:0]            sum_c;
    logic signed [35:0]                  m_sum;
    logic signed [dagm_pkg::VAL_W-1:0]   m_new;

    always_comb begin
        cnt_sum = {1'b0, p_cnt_reg[48:16]} + 34'd65536;
        cnt_new = (|cnt_sum[33:32]) ? '1 : cnt_sum[31:0];
        sum_a   = {1'b0, p_hi_reg} + 50'(p_lo_reg);
        sum_b   = (|sum_a[49:48]) ? '1 : sum_a[47:0];
        sum_c   = {1'b0, sum_b} + {1'b0, g_sq_reg};
        sum_new = sum_c[dagm_pkg::SUM_W] ? '1 : sum_c[dagm_pkg::SUM_W-1:0];
        m_sum   = 36'(mom_reg) + 36'(signed'(m_prod_reg[50:16]));
        m_new   = dagm_pkg::sat32(dagm_pkg::WIDE_W'(m_sum));
        if (s2_reg.op == dagm_pkg::OP_LOAD) begin
            st_wr.cnt = '0;
            st_wr.sum = dagm_pkg::SUM_W'(iss_reg);
            st_wr.mom = '0;
        end else begin
            st_wr.cnt = cnt_new;
            st_wr.sum = sum_new;
            st_wr.mom = m_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_rd_reg <= st_mem[dagm_pkg::ADDR_W'(s_element_index)];
            if (s2_reg.valid && s2_reg.in_range) begin
                st_mem[dagm_pkg::ADDR_W'(s2_reg.idx)] <= st_wr;
            end
        end
    end

    logic [dagm_pkg::CNT_W-1:0]          cnt3_reg;
    logic [dagm_pkg::SUM_W-1:0]          sum3_reg;
    logic signed [dagm_pkg::VAL_W-1:0]   mom3_reg;

    // Stage 3: momentum magnitude times learning rate.
    logic [dagm_pkg::VAL_W-1:0]          m_abs;

    always_comb begin
        m_abs        = mom3_reg[dagm_pkg::VAL_W-1] ? 32'(-mom3_reg) : 32'(mom3_reg);
        div1_side_in = s3_reg;
        div1_side_in.neg = mom3_reg[dagm_pkg::VAL_W-1];
        div1_side_in.mag = dagm_pkg::MAG_W'(m_abs) * dagm_pkg::MAG_W'(lr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
        end else if (adv) begin
            s1_reg.valid    <= accept;
            s1_reg.op       <= dagm_pkg::op_t'(s_opcode);
            s1_reg.in_range <= s_in_range;
            s1_reg.idx      <= s_element_index;
            s1_reg.neg      <= 1'b0;
            s1_reg.zero_den <= 1'b0;
            s1_reg.val      <= s_operand_value;
            s1_reg.mag      <= '0;
            s2_reg          <= s1_reg;
            s3_reg          <= s2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_cnt_reg  <= p_cnt;
            p_hi_reg   <= p_hi;
            p_lo_reg   <= p_lo[32:16];
            g_sq_reg   <= g_sq[63:16];
            m_prod_reg <= m_prod;
            mom_reg    <= st_rd_reg.mom;
            cnt3_reg   <= cnt_new;
            sum3_reg   <= sum_new;
            mom3_reg   <= m_new;
        end
    end

    // Mean square ratio as Q.32: square sum scaled by 2^32 over the step count.
    dagm_div u_div_ratio (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .side_in    (div1_side_in),
        .rem_in     (dagm_pkg::DEN_W'(sum3_reg[47:32])),
        .bits_in    ({sum3_reg[31:0], 32'd0}),
        .divisor_in ({1'b0, cnt3_reg}),
        .side_out   (div1_side_out),
        .quot_out   (div1_quot)
    );

    dagm_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .side_in  (div1_side_out),
        .x_in     (div1_quot),
        .side_out (sq_side_out),
        .root_out (sq_root)
    );

    logic [dagm_pkg::DEN_W-1:0] denom;

    always_comb begin
        denom                 = {1'b0, sq_root} + dagm_pkg::DEN_W'(eps_reg);
        div2_side_in          = sq_side_out;
        div2_side_in.zero_den = (denom == '0);
    end

    dagm_div u_div_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .side_in    (div2_side_in),
        .rem_in     ('0),
        .bits_in    (dagm_pkg::DIV_W'(sq_side_out.mag)),
        .divisor_in (denom),
        .side_out   (div2_side_out),
        .quot_out   (div2_quot)
    );

    // Weight memory: read as an item enters the final stage, written as it leaves.
    logic signed [dagm_pkg::VAL_W-1:0] w_mem [dagm_pkg::VECTOR_LENGTH];
    logic signed [dagm_pkg::VAL_W-1:0] w_rd_reg;
    logic [dagm_pkg::MAG_W-1:0]        f_quot_reg;
    logic signed [dagm_pkg::WIDE_W-1:0] w_wide, chg_wide, w_diff;
    logic signed [dagm_pkg::VAL_W-1:0] w_new;

    always_comb begin
        w_wide   = dagm_pkg::WIDE_W'(w_rd_reg);
        chg_wide = signed'(dagm_pkg::WIDE_W'(f_quot_reg));
        w_diff   = f_reg.neg ? (w_wide + chg_wide) : (w_wide - chg_wide);
        if (!f_reg.in_range) begin
            w_new = '0;
        end else if (f_reg.op == dagm_pkg::OP_LOAD) begin
            w_new = f_reg.val;
        end else if (f_reg.zero_den) begin
            w_new = w_rd_reg;
        end else begin
            w_new = dagm_pkg::sat32(w_diff);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w_rd_reg   <= w_mem[dagm_pkg::ADDR_W'(div2_side_out.idx)];
            f_quot_reg <= div2_quot[dagm_pkg::MAG_W-1:0];
            if (f_reg.valid && f_reg.in_range) begin
                w_mem[dagm_pkg::ADDR_W'(f_reg.idx)] <= w_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg.valid <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                f_reg <= div2_side_out;
            end
            if (out_free) begin
                m_valid_reg <= f_reg.valid;
                m_idx_reg   <= f_reg.idx;
                m_w_reg     <= w_new;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_idx_reg;
    assign m_new_weight   = m_w_reg;

endmodule

// ===== rtl/dagm_checker.sv =====
// Port-level assertions for the dense AdaGrad momentum update block, bound to its top.
// Depends on dagm_pkg for port widths.
module dagm_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [dagm_pkg::IDX_W-1:0]           s_element_index,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [dagm_pkg::IDX_W-1:0]           m_result_index,
    input logic signed [dagm_pkg::VAL_W-1:0]    m_new_weight
);

    logic s_xfer;
    assign s_xfer = s_valid && s_ready;

    // A stalled result transfer keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_index) && $stable(m_new_weight))
        else $error("result changed while stalled");

    // Nothing is offered right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The interlock keeps an index apart from the item accepted just before it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && $past(aresetn) && $past(s_xfer) |->
            s_element_index != $past(s_element_index))
        else $error("same index accepted in consecutive cycles");

    // The interlock likewise keeps an index apart from the item in stage 2 when it is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && $past(aresetn) && $past(aresetn, 2) && $past(s_xfer, 2) |->
            s_element_index != $past(s_element_index, 2))
        else $error("same index accepted two cycles apart");

endmodule

bind dense_adagrad_momentum_update dagm_checker u_dagm_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_element_index (s_element_index),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_index  (m_result_index),
    .m_new_weight    (m_new_weight)
);

// ===== dv/dense_adagrad_momentum_update_test.sv =====
// Self-checking testbench for dense_adagrad_momentum_update: directed tables, then random
// load/update traffic checked against an in-bench fixed-point predictor.
// Depends on rtl/dagm_pkg.sv and rtl/dense_adagrad_momentum_update.sv.
`timescale 1ns / 100ps

module dense_adagrad_momentum_update_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [63:0] SUM_SAT = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [dagm_pkg::IDX_W-1:0]        idx;
        logic signed [dagm_pkg::VAL_W-1:0] weight;
    } weight_result_t;

    typedef struct {
        dagm_pkg::op_t                     op;
        logic [dagm_pkg::IDX_W-1:0]        idx;
        logic signed [dagm_pkg::VAL_W-1:0] val;
        bit                                typed;
        logic signed [dagm_pkg::VAL_W-1:0] weight;
    } stim_row_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [dagm_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [dagm_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                s_valid;
    logic                                s_ready;
    logic                                s_opcode;
    logic [dagm_pkg::IDX_W-1:0]          s_element_index;
    logic signed [dagm_pkg::VAL_W-1:0]   s_operand_value;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [dagm_pkg::IDX_W-1:0]          m_result_index;
    logic signed [dagm_pkg::VAL_W-1:0]   m_new_weight;

    dense_adagrad_momentum_update u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_element_index(s_element_index),
        .s_operand_value(s_operand_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_index (m_result_index),
        .m_new_weight   (m_new_weight)
    );

    logic [31:0] lr_q, eps_q, gd_q, md_q, iss_q;
    logic signed [31:0] weight_q [dagm_pkg::VECTOR_LENGTH];
    logic [31:0]        count_q  [dagm_pkg::VECTOR_LENGTH];
    logic [63:0]        sqsum_q  [dagm_pkg::VECTOR_LENGTH];
    logic signed [31:0] mom_q    [dagm_pkg::VECTOR_LENGTH];
    bit                 loaded   [dagm_pkg::VECTOR_LENGTH];

    weight_result_t pending_weights[$];
    int send_idle_pct;
    int recv_idle_pct;
    int errors = 0;
    int cycles = 0;
    int transfers_in;
    int transfers_out = 0;
    int zero_den_hits;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] next_weight(input dagm_pkg::op_t op,
                                                       input logic [9:0] idx,
                                                       input logic signed [31:0] val);
        logic [63:0]        cnt, sum, mag_g, q, rem, r32, denom, mag;
        logic signed [63:0] g, m, k, change;
        logic signed [31:0] w;
        if (op == dagm_pkg::OP_LOAD) begin
            weight_q[idx] = val;
            count_q[idx]  = '0;
            sqsum_q[idx]  = {32'd0, iss_q};
            mom_q[idx]    = '0;
            loaded[idx]   = 1'b1;
            return val;
        end
        g = val;
        cnt = ((64'(gd_q) * 64'(count_q[idx])) >> 16) + 64'd65536;
        if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
        count_q[idx] = cnt[31:0];
        sum = sqsum_q[idx] & SUM_SAT;
        sum = (sum >> 16) * 64'(gd_q) + (((sum & 64'hFFFF) * 64'(gd_q)) >> 16);
        if (sum > SUM_SAT) sum = SUM_SAT;
        mag_g = (g < 0) ? 64'(-g) : 64'(g);
        sum = sum + ((mag_g * mag_g) >> 16);
        if (sum > SUM_SAT) sum = SUM_SAT;
        sqsum_q[idx] = sum;
        m = mom_q[idx];
        k = 64'sd65536 - $signed(64'(md_q));
        m = clip32(m + (((g - m) * k) >>> 16));
        mom_q[idx] = m[31:0];
        q = (sum << 16) / cnt;
        rem = (sum << 16) % cnt;
        r32 = (q << 16) + ((rem << 16) / cnt);
        denom = int_sqrt(r32) + 64'(eps_q);
        w = weight_q[idx];
        if (denom != 0) begin
            mag = ((m < 0) ? 64'(-m) : 64'(m)) * 64'(lr_q);
            mag = mag / denom;
            change = $signed(mag);
            if (m < 0) change = -change;
            w = clip32(64'(w) - change);
            weight_q[idx] = w;
        end else begin
            zero_den_hits++;
        end
        return w;
    endfunction

    // Leaves the write enable high; write_all drops it after the last register.
    task automatic write_reg(input dagm_pkg::cfg_idx_t which, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge aclk);
        case (which)
            dagm_pkg::CFG_LEARNING_RATE:      lr_q  = value & 32'h1FFFF;
            dagm_pkg::CFG_EPSILON:            eps_q = value & 32'h1FFFF;
            dagm_pkg::CFG_GRAD_DECAY:         gd_q  = value & 32'h1FFFF;
            dagm_pkg::CFG_MOMENTUM_DECAY:     md_q  = value & 32'h1FFFF;
            dagm_pkg::CFG_INITIAL_SQUARE_SUM: iss_q = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] lr, input logic [31:0] eps,
                             input logic [31:0] gd, input logic [31:0] md,
                             input logic [31:0] iss);
        write_reg(dagm_pkg::CFG_LEARNING_RATE, lr);
        write_reg(dagm_pkg::CFG_EPSILON, eps);
        write_reg(dagm_pkg::CFG_GRAD_DECAY, gd);
        write_reg(dagm_pkg::CFG_MOMENTUM_DECAY, md);
        write_reg(dagm_pkg::CFG_INITIAL_SQUARE_SUM, iss);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_weights.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // The caller's posedge context is kept: every call returns right after an edge.
    task automatic send_item(input dagm_pkg::op_t op, input logic [9:0] idx,
                             input logic signed [31:0] val,
                             input bit typed, input logic signed [31:0] typed_weight);
        weight_result_t exp_w;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_element_index <= idx;
        s_operand_value <= val;
        do @(posedge aclk); while (!s_ready);
        exp_w.idx    = idx;
        exp_w.weight = next_weight(op, idx, val);
        if (typed) exp_w.weight = typed_weight;
        pending_weights.push_back(exp_w);
        transfers_in++;
    endtask

    task automatic random_item(input int hot_base);
        logic [9:0]         idx;
        logic signed [31:0] val;
        dagm_pkg::op_t      op;
        case ($urandom_range(9))
            0, 1:    val = $urandom;
            2:       val = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: val = $signed($urandom_range(2 * 393216) - 393216);
        endcase
        if ($urandom_range(4) == 0) idx = 10'($urandom);
        else idx = 10'(hot_base + $urandom_range(7));
        op = ($urandom_range(11) == 0) ? dagm_pkg::OP_LOAD : dagm_pkg::OP_UPDATE;
        if (!loaded[idx]) op = dagm_pkg::OP_LOAD;
        send_item(op, idx, val, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        weight_result_t exp_w;
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            transfers_out++;
            if (pending_weights.size() == 0) begin
                errors++;
                $display("%0t: unexpected result index %0d weight %0d", $time,
                         m_result_index, m_new_weight);
            end else begin
                exp_w = pending_weights.pop_front();
                if (m_result_index !== exp_w.idx) begin
                    errors++;
                    $display("%0t: result_index expected %0d actual %0d", $time,
                             exp_w.idx, m_result_index);
                end
                if (m_new_weight !== exp_w.weight) begin
                    errors++;
                    $display("%0t: new_weight (index %0d) expected %0d actual %0d", $time,
                             exp_w.idx, exp_w.weight, m_new_weight);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_weights.size());
            $display("[dense_adagrad_momentum_update] ERROR");
            $finish;
        end
    end

    stim_row_t directed[$];

    initial begin
        int n;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_opcode = 1'b0;
        s_element_index = '0;
        s_operand_value = '0;
        transfers_in = 0;
        zero_den_hits = 0;
        send_idle_pct = 31;
        recv_idle_pct = 84;
        lr_q  = 32'(dagm_pkg::LR_RESET);
        eps_q = 32'(dagm_pkg::EPS_RESET);
        gd_q  = 32'(dagm_pkg::GD_RESET);
        md_q  = 32'(dagm_pkg::MD_RESET);
        iss_q = dagm_pkg::ISS_RESET;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: extremes of weight and index, then updates on them.
        directed = '{
            '{dagm_pkg::OP_LOAD,   10'd0,    32'sh7fffffff, 1'b1, 32'sh7fffffff},
            '{dagm_pkg::OP_LOAD,   10'd1023, 32'sh80000000, 1'b1, 32'sh80000000},
            '{dagm_pkg::OP_LOAD,   10'd5,    32'sd0,        1'b1, 32'sd0},
            '{dagm_pkg::OP_LOAD,   10'd682,  32'sh5555aaaa, 1'b1, 32'sh5555aaaa},
            '{dagm_pkg::OP_LOAD,   10'd341,  -32'sd65536,   1'b1, -32'sd65536},
            '{dagm_pkg::OP_UPDATE, 10'd0,    32'sh80000000, 1'b0, 0},
            '{dagm_pkg::OP_UPDATE, 10'd1023, 32'sh7fffffff, 1'b0, 0},
            '{dagm_pkg::OP_UPDATE, 10'd5,    32'sd65536,    1'b0, 0},
            '{dagm_pkg::OP_UPDATE, 10'd5,    -32'sd65536,   1'b0, 0},
            '{dagm_pkg::OP_UPDATE, 10'd682,  32'sh2aaa5555, 1'b0, 0},
            '{dagm_pkg::OP_UPDATE, 10'd341,  32'sd0,        1'b0, 0},
            '{dagm_pkg::OP_UPDATE, 10'd0,    32'sh80000000, 1'b0, 0},
            '{dagm_pkg::OP_UPDATE, 10'd1023, 32'sh7fffffff, 1'b0, 0}
        };
        foreach (directed[i])
            send_item(directed[i].op, directed[i].idx, directed[i].val,
                      directed[i].typed, directed[i].weight);
        s_valid <= 1'b0;
        wait_idle();

        // No epsilon and an empty square sum: a zero gradient leaves the weight as it is.
        write_all(32'h1FFFF, 32'd0, 32'd65536, 32'd0, 32'd0);
        directed = '{
            '{dagm_pkg::OP_LOAD,   10'd9, 32'sd123456, 1'b1, 32'sd123456},
            '{dagm_pkg::OP_UPDATE, 10'd9, 32'sd0,      1'b1, 32'sd123456},
            '{dagm_pkg::OP_UPDATE, 10'd9, 32'sd0,      1'b1, 32'sd123456},
            '{dagm_pkg::OP_UPDATE, 10'd9, 32'sd3,      1'b0, 0},
            '{dagm_pkg::OP_LOAD,   10'd9, -32'sd7,     1'b1, -32'sd7},
            '{dagm_pkg::OP_UPDATE, 10'd9, -32'sd1,     1'b0, 0}
        };
        foreach (directed[i])
            send_item(directed[i].op, directed[i].idx, directed[i].val,
                      directed[i].typed, directed[i].weight);
        s_valid <= 1'b0;
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 84 : 0;
            recv_idle_pct = (phase < 2) ? 84 : (phase < 4) ? 31 : 0;
            case (phase)
                0: write_all(32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 32'hFFFF_FFFF);
                1: write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                2: write_all(32'd65536, 32'd1, 32'd65536, 32'd65536, 32'd1);
                default: write_all($urandom_range(65536), $urandom_range(65536),
                                   $urandom_range(32768, 65536), $urandom_range(65536), $urandom);
            endcase
            n = 230;
            for (int i = 0; i < n; i++) begin
                random_item($urandom_range(1016));
                if (i == n / 2 && phase == 3) begin
                    s_valid <= 1'b0;
                    while (pending_weights.size() != 0) @(posedge aclk);
                end
            end
            s_valid <= 1'b0;
            wait_idle();
        end

        $display("Sent %0d items and checked %0d results over 8 register settings,",
                 transfers_in, transfers_out);
        $display("with %0d zero-denominator updates and three back-pressure patterns.",
                 zero_den_hits);
        if (errors == 0) begin
            $display("[dense_adagrad_momentum_update] OK");
        end else begin
            $display("[dense_adagrad_momentum_update] ERROR");
        end
        $finish;
    end

endmodule
